[src/mra_pkg.sv]
package mra_pkg;

    // term and target widths
    localparam int TERM_W    = 48;
    localparam int FRAC_BITS = 32;
    localparam int TARGET_W  = FRAC_BITS + 1;
    localparam int LIMIT_W   = 7;
    localparam int MAX_STEPS = 64;

    // scaled error |target*den - num*2^frac| needs target plus term bits
    localparam int ERR_W = TARGET_W + TERM_W;

    // multiplier chunking: a operand in A_CHUNKS digits, b operand in B_CHUNKS digits
    localparam int A_CHUNKS  = 3;
    localparam int A_CHUNK_W = (ERR_W + A_CHUNKS - 1) / A_CHUNKS;
    localparam int B_CHUNKS  = 2;
    localparam int B_CHUNK_W = (TERM_W + B_CHUNKS - 1) / B_CHUNKS;
    localparam int PP_W      = A_CHUNK_W + B_CHUNK_W;
    localparam int ACC_W     = A_CHUNKS * A_CHUNK_W + B_CHUNKS * B_CHUNK_W;
    localparam int SH_W      = $clog2(ACC_W);

    // stream payload layout
    localparam int IN_W     = ((TARGET_W + LIMIT_W + 7) / 8) * 8;
    localparam int REL_W    = 2;
    localparam int OUT_BITS = LIMIT_W + 6 * TERM_W + REL_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // relation codes
    localparam logic [REL_W-1:0] REL_EQ    = 2'd0;
    localparam logic [REL_W-1:0] REL_BELOW = 2'd1;
    localparam logic [REL_W-1:0] REL_ABOVE = 2'd2;

    // multiplier operand selection
    localparam logic [1:0] MSEL_TGT_AD  = 2'd0;
    localparam logic [1:0] MSEL_ERR_PD  = 2'd1;
    localparam logic [1:0] MSEL_PERR_AD = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       med;
        logic       err;
        logic       save_p2;
        logic       cmp;
        logic       emit;
        logic       mul_start;
        logic [1:0] mul_sel;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic mul_done;
        logic first;
        logic last;
        logic limit_zero;
        logic out_busy;
    } t_stat;

endpackage

[src/mediant_rational_approximator.sv]
// Stern-Brocot rational approximation of a target fraction (33-bit, 2^32 = 1.0). Each accepted
// request starts from bounds 0/1 and 1/1 and produces one result per mediant step, up to the
// step limit (saturated to 64; a limit of 0 gives no result), stopping early when the mediant
// equals the target; tlast marks the final result. One request is worked on at a time and the
// input is ready again once the final result sits in the output register. A single shared
// multiplier computes one 27x24-bit partial product per cycle, so each cross product passes
// through start, six partial products, final accumulate and done; every step after the first
// adds two extra products for the error-growth check, and a stalled output delays the emit.
module mediant_rational_approximator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // target [32:0], step_limit [39:33]
    input  logic [mra_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // step_index [6:0], lower_num [54:7], lower_den [102:55], upper_num [150:103],
    // upper_den [198:151], approx_num [246:199], approx_den [294:247],
    // relation [296:295], error_grew [297], zero fill above
    output logic [mra_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);
    import mra_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    mra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mra_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in_data  (i_s_axis_tdata),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

[src/mra_mul.sv]
module mra_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mra_pkg::ERR_W-1:0]  i_a,
    input  logic [mra_pkg::TERM_W-1:0] i_b,
    output logic                       o_done,
    output logic [mra_pkg::ACC_W-1:0]  o_prod
);
    import mra_pkg::*;

    localparam int IA_W = (A_CHUNKS > 1) ? $clog2(A_CHUNKS) : 1;
    localparam int JB_W = (B_CHUNKS > 1) ? $clog2(B_CHUNKS) : 1;

    logic [A_CHUNKS-1:0][A_CHUNK_W-1:0] r_a;
    logic [B_CHUNKS-1:0][B_CHUNK_W-1:0] r_b;
    logic [IA_W-1:0]  r_ia;
    logic [JB_W-1:0]  r_jb;
    logic             r_issue;
    logic             r_pv;
    logic             r_plast;
    logic             r_done;
    logic [PP_W-1:0]  r_prod;
    logic [SH_W-1:0]  r_sh;
    logic [ACC_W-1:0] r_acc;
    logic             w_issue_last;

    assign w_issue_last = (r_ia == IA_W'(A_CHUNKS - 1)) && (r_jb == JB_W'(B_CHUNKS - 1));

    // sequencing of partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && w_issue_last) begin
                r_issue <= 1'b0;
            end
            r_pv    <= r_issue;
            r_plast <= r_issue && w_issue_last;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_pv && r_plast) begin
                r_done <= 1'b1;
            end
        end
    end

    // operand digits, one partial product a cycle, shifted accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= PP_W'(r_a[r_ia]) * PP_W'(r_b[r_jb]);
        r_sh   <= SH_W'(r_ia) * SH_W'(A_CHUNK_W) + SH_W'(r_jb) * SH_W'(B_CHUNK_W);
        if (i_start) begin
            r_a   <= (A_CHUNKS * A_CHUNK_W)'(i_a);
            r_b   <= (B_CHUNKS * B_CHUNK_W)'(i_b);
            r_ia  <= '0;
            r_jb  <= '0;
            r_acc <= '0;
        end else begin
            if (r_issue) begin
                if (r_ia == IA_W'(A_CHUNKS - 1)) begin
                    r_ia <= '0;
                    r_jb <= r_jb + 1'b1;
                end else begin
                    r_ia <= r_ia + 1'b1;
                end
            end
            if (r_pv) begin
                r_acc <= r_acc + (ACC_W'(r_prod) << r_sh);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[src/mra_dp.sv]
module mra_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mra_pkg::t_cmd             i_cmd,
    output mra_pkg::t_stat            o_stat,
    input  logic [mra_pkg::IN_W-1:0]  i_in_data,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [mra_pkg::OUT_W-1:0] o_m_tdata,
    output logic                      o_m_tlast
);
    import mra_pkg::*;

    logic [TARGET_W-1:0] r_tgt;
    logic [LIMIT_W-1:0]  r_lim;
    logic [LIMIT_W-1:0]  r_step;
    logic                r_first;
    logic [TERM_W-1:0]   r_ln, r_ld, r_un, r_ud;
    logic [TERM_W-1:0]   r_an, r_ad, r_pd;
    logic [ERR_W-1:0]    r_err, r_perr;
    logic [REL_W-1:0]    r_rel;
    logic                r_grew;
    logic [ACC_W-1:0]    r_p2;
    logic                r_out_valid;
    logic                r_out_last;
    logic [OUT_W-1:0]    r_out_data;

    logic [LIMIT_W-1:0]  w_lim_in;
    logic [LIMIT_W-1:0]  w_lim_sat;
    logic [ERR_W-1:0]    w_mul_a;
    logic [TERM_W-1:0]   w_mul_b;
    logic                w_mul_done;
    logic [ACC_W-1:0]    w_prod;
    logic [ERR_W-1:0]    w_p1, w_y, w_diff;
    logic                w_ge;
    logic [REL_W-1:0]    w_rel;
    logic                w_last;

    // step limit from the request, saturated
    assign w_lim_in  = i_in_data[TARGET_W +: LIMIT_W];
    assign w_lim_sat = (w_lim_in > LIMIT_W'(MAX_STEPS)) ? LIMIT_W'(MAX_STEPS) : w_lim_in;

    // multiplier operand selection
    always_comb begin
        case (i_cmd.mul_sel)
            MSEL_TGT_AD: begin
                w_mul_a = ERR_W'(r_tgt);
                w_mul_b = r_ad;
            end
            MSEL_ERR_PD: begin
                w_mul_a = r_err;
                w_mul_b = r_pd;
            end
            default: begin
                w_mul_a = r_perr;
                w_mul_b = r_ad;
            end
        endcase
    end

    mra_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // cross-multiplied compare of target*den against num*2^frac
    assign w_p1   = w_prod[ERR_W-1:0];
    assign w_y    = ERR_W'({r_an, {FRAC_BITS{1'b0}}});
    assign w_ge   = (w_p1 >= w_y);
    assign w_diff = w_ge ? (w_p1 - w_y) : (w_y - w_p1);
    assign w_rel  = (w_p1 == w_y) ? REL_EQ : (w_ge ? REL_ABOVE : REL_BELOW);
    assign w_last = (r_rel == REL_EQ) || (r_step == r_lim);

    // per-target state: bounds, step count, previous mediant denominator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt   <= '0;
            r_lim   <= '0;
            r_step  <= '0;
            r_first <= 1'b1;
            r_ln    <= '0;
            r_ld    <= TERM_W'(1);
            r_un    <= TERM_W'(1);
            r_ud    <= TERM_W'(1);
            r_pd    <= TERM_W'(1);
        end else if (i_cmd.load) begin
            r_tgt   <= i_in_data[TARGET_W-1:0];
            r_lim   <= w_lim_sat;
            r_step  <= '0;
            r_first <= 1'b1;
            r_ln    <= '0;
            r_ld    <= TERM_W'(1);
            r_un    <= TERM_W'(1);
            r_ud    <= TERM_W'(1);
            r_pd    <= TERM_W'(1);
        end else begin
            if (i_cmd.med) begin
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.emit) begin
                if (r_rel == REL_BELOW) begin
                    r_un <= r_an;
                    r_ud <= r_ad;
                end else if (r_rel == REL_ABOVE) begin
                    r_ln <= r_an;
                    r_ld <= r_ad;
                end
                r_pd    <= r_ad;
                r_first <= 1'b0;
            end
        end
    end

    // step working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.med) begin
            r_an <= r_ln + r_un;
            r_ad <= r_ld + r_ud;
        end
        if (i_cmd.err) begin
            r_err  <= w_diff;
            r_rel  <= w_rel;
            r_grew <= 1'b0;
        end
        if (i_cmd.save_p2) begin
            r_p2 <= w_prod;
        end
        if (i_cmd.cmp) begin
            r_grew <= (r_p2 > w_prod);
        end
        if (i_cmd.emit) begin
            r_perr <= r_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_last <= w_last;
            r_out_data <= OUT_W'({r_grew, r_rel, r_ad, r_an, r_ud, r_un, r_ld, r_ln, r_step});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // status
    assign o_stat.mul_done   = w_mul_done;
    assign o_stat.first      = r_first;
    assign o_stat.last       = w_last;
    assign o_stat.limit_zero = (w_lim_in == '0);
    assign o_stat.out_busy   = r_out_valid && !i_m_tready;

endmodule

[src/mra_ctrl.sv]
module mra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  mra_pkg::t_stat i_stat,
    output mra_pkg::t_cmd  o_cmd
);
    import mra_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MED  = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_W1   = 4'd3;
    localparam logic [3:0] S_ERR  = 4'd4;
    localparam logic [3:0] S_M2   = 4'd5;
    localparam logic [3:0] S_W2   = 4'd6;
    localparam logic [3:0] S_M3   = 4'd7;
    localparam logic [3:0] S_W3   = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    // step sequencing: mediant, error multiply, growth check (skipped on the first step), emit
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MSEL_TGT_AD;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.limit_zero) begin
                        n_state = S_MED;
                    end
                end
            end
            S_MED: begin
                o_cmd.med = 1'b1;
                n_state   = S_M1;
            end
            S_M1: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_TGT_AD;
                n_state         = S_W1;
            end
            S_W1: begin
                if (i_stat.mul_done) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = i_stat.first ? S_EMIT : S_M2;
            end
            S_M2: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_ERR_PD;
                n_state         = S_W2;
            end
            S_W2: begin
                if (i_stat.mul_done) begin
                    n_state = S_M3;
                end
            end
            S_M3: begin
                o_cmd.save_p2   = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MSEL_PERR_AD;
                n_state         = S_W3;
            end
            S_W3: begin
                if (i_stat.mul_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.last ? S_IDLE : S_MED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/mra_checker.sv]
module mra_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_m_tvalid,
    input logic                      i_m_tready,
    input logic [mra_pkg::OUT_W-1:0] i_m_tdata,
    input logic                      i_m_tlast
);
    import mra_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("result changed while stalled");

    // relation code is always a defined one
    a_rel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[296:295] != 2'd3)
        else $error("undefined relation code");

    // exact hit ends the run
    a_eq_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[296:295] == REL_EQ |-> i_m_tlast)
        else $error("exact match without last");

    // first step never reports a growing error
    a_first_grew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[6:0] == 7'd1 |-> !i_m_tdata[297])
        else $error("error growth flagged on first step");

    // mediant is the sum of the bounds
    a_mediant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[246:199] == i_m_tdata[54:7] + i_m_tdata[150:103]
            && i_m_tdata[294:247] == i_m_tdata[102:55] + i_m_tdata[198:151])
        else $error("mediant does not match bounds");

endmodule

bind mediant_rational_approximator mra_checker u_mra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);
